[rtl/core/hlcd_pkg.sv]
// Shared types and constants of the highway lane change decider.
package hlcd_pkg;

  localparam int LaneW   = 2;
  localparam int PtsW    = 6;
  localparam int SW      = 20;
  localparam int DW      = 13;
  localparam int VW      = 14;
  localparam int SqW     = 28;
  localparam int SpdW    = 14;
  localparam int ProdW   = SpdW + PtsW;
  localparam int PredW   = SW + 1;
  localparam int SpeedW  = 7;
  localparam int CntW    = 7;
  localparam int AddrW   = 5;
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);

  localparam int DefLaneCount  = 3;
  localparam int DefPathPoints = 50;

  // 0.02 s per path point: divide by 50 through a scaled reciprocal
  localparam int PointsPerSec = 50;
  localparam int RecipShift   = 32;
  localparam int RecipW       = 27;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << RecipShift) + 64'(PointsPerSec) - 64'd1) / 64'(PointsPerSec));
  localparam int QuotW = 14;

  localparam int RootSteps = SpdW;

  // register indexes
  localparam logic [2:0] RegAheadGap   = 3'd0;
  localparam logic [2:0] RegBehindGap  = 3'd1;
  localparam logic [2:0] RegFollowGap  = 3'd2;
  localparam logic [2:0] RegSideWindow = 3'd3;
  localparam logic [2:0] RegLaneWidth  = 3'd4;
  localparam logic [2:0] RegMinChange  = 3'd5;
  localparam logic [2:0] RegSpeedLimit = 3'd6;

  typedef enum logic [2:0] {
    DecAccel = 3'd0,
    DecHold  = 3'd1,
    DecSlow  = 3'd2,
    DecLeft  = 3'd3,
    DecRight = 3'd4
  } decision_e;

  typedef struct packed {
    logic [15:0]       ahead_gap;
    logic [15:0]       behind_gap;
    logic [15:0]       follow_gap;
    logic [11:0]       side_window;
    logic [9:0]        lane_width;
    logic [CntW-1:0]   min_change;
    logic [SpeedW-1:0] speed_limit;
  } cfg_t;

  // one classified item on its way from front to back
  typedef struct packed {
    logic                  first;
    logic                  last;
    logic                  has_vehicle;
    logic [SW-1:0]         ref_s;
    logic signed [DW-1:0]  ego_d;
    logic [PtsW-1:0]       points;
    logic signed [DW-1:0]  other_d;
    logic [SW-1:0]         other_s;
    logic [SqW-1:0]        speed_sq;
  } entry_t;

endpackage

[rtl/core/hlcd_if.sv]
// Channel interfaces: vehicle items in, frame decisions out.
interface hlcd_in_if;
  logic                  valid;
  logic                  ready;
  logic                  frame_first;
  logic                  frame_last;
  logic                  has_vehicle;
  logic [19:0]           ego_s_cm;
  logic [19:0]           path_end_s_cm;
  logic signed [12:0]    ego_d_cm;
  logic [5:0]            path_points_left;
  logic signed [12:0]    other_d_cm;
  logic signed [13:0]    other_vx_cms;
  logic signed [13:0]    other_vy_cms;
  logic [19:0]           other_s_cm;

  modport source (
    output valid, frame_first, frame_last, has_vehicle, ego_s_cm, path_end_s_cm,
           ego_d_cm, path_points_left, other_d_cm, other_vx_cms, other_vy_cms,
           other_s_cm,
    input  ready
  );
  modport sink (
    input  valid, frame_first, frame_last, has_vehicle, ego_s_cm, path_end_s_cm,
           ego_d_cm, path_points_left, other_d_cm, other_vx_cms, other_vy_cms,
           other_s_cm,
    output ready
  );
endinterface

interface hlcd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] lane_now;
  logic [6:0] target_speed_half_mph;
  logic [2:0] decision;
  logic       blocked_ahead;

  modport source (
    output valid, lane_now, target_speed_half_mph, decision, blocked_ahead,
    input  ready
  );
  modport sink (
    input  valid, lane_now, target_speed_half_mph, decision, blocked_ahead,
    output ready
  );
endinterface

[rtl/core/hlcd_front.sv]
// Front end: accepts items, latches frame ego data, squares the velocity.
module hlcd_front #(
  parameter int PATH_POINTS = hlcd_pkg::DefPathPoints
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hlcd_in_if.sink           in_i,
  input  logic              full_i,
  output logic              push_o,
  output hlcd_pkg::entry_t  entry_o
);

  logic [hlcd_pkg::SW-1:0]        ref_s_q, ref_s_d;
  logic signed [hlcd_pkg::DW-1:0] ego_d_q, ego_d_d;
  logic [hlcd_pkg::PtsW-1:0]      pts_q, pts_d, pts_sat;
  logic [2*hlcd_pkg::VW-1:0]      vx_sq, vy_sq;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && in_i.ready;

  assign pts_sat = (in_i.path_points_left > hlcd_pkg::PtsW'(PATH_POINTS)) ?
                   hlcd_pkg::PtsW'(PATH_POINTS) : in_i.path_points_left;

  always_comb begin
    ref_s_d = ref_s_q;
    ego_d_d = ego_d_q;
    pts_d   = pts_q;
    if (in_i.frame_first) begin
      pts_d   = pts_sat;
      ref_s_d = (pts_sat != '0) ? in_i.path_end_s_cm : in_i.ego_s_cm;
      ego_d_d = in_i.ego_d_cm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_s_q <= '0;
      ego_d_q <= '0;
      pts_q   <= '0;
    end else if (push_o) begin
      ref_s_q <= ref_s_d;
      ego_d_q <= ego_d_d;
      pts_q   <= pts_d;
    end
  end

  assign vx_sq = (2*hlcd_pkg::VW)'(in_i.other_vx_cms * in_i.other_vx_cms);
  assign vy_sq = (2*hlcd_pkg::VW)'(in_i.other_vy_cms * in_i.other_vy_cms);

  always_comb begin
    entry_o.first       = in_i.frame_first;
    entry_o.last        = in_i.frame_last;
    entry_o.has_vehicle = in_i.has_vehicle;
    entry_o.ref_s       = ref_s_d;
    entry_o.ego_d       = ego_d_d;
    entry_o.points      = pts_d;
    entry_o.other_d     = in_i.other_d_cm;
    entry_o.other_s     = in_i.other_s_cm;
    entry_o.speed_sq    = hlcd_pkg::SqW'(vx_sq) + hlcd_pkg::SqW'(vy_sq);
  end

endmodule

[rtl/core/hlcd_fifo.sv]
// Short queue of classified items between front and back.
module hlcd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hlcd_pkg::entry_t  entry_i,
  input  logic              pop_i,
  output hlcd_pkg::entry_t  entry_o,
  output logic              full_o,
  output logic              empty_o
);

  hlcd_pkg::entry_t              mem_q [hlcd_pkg::QDepth];
  logic [hlcd_pkg::QPtrW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [hlcd_pkg::QPtrW:0]      cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == (hlcd_pkg::QPtrW+1)'(hlcd_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

[rtl/core/hlcd_back.sv]
// Back end: speed root, s prediction, gap checks and the frame decision.
module hlcd_back #(
  parameter int LANE_COUNT = hlcd_pkg::DefLaneCount
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hlcd_pkg::cfg_t    cfg_i,
  input  hlcd_pkg::entry_t  entry_i,
  input  logic              empty_i,
  output logic              pop_o,
  hlcd_out_if.source        out_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StRoot   = 3'd1;
  localparam logic [2:0] StMul1   = 3'd2;
  localparam logic [2:0] StMul2   = 3'd3;
  localparam logic [2:0] StEval   = 3'd4;
  localparam logic [2:0] StDecide = 3'd5;

  localparam logic [hlcd_pkg::LaneW-1:0] LastLane = hlcd_pkg::LaneW'(LANE_COUNT - 1);
  localparam int DiffW = hlcd_pkg::PredW + 1;
  localparam int MqW   = hlcd_pkg::ProdW + hlcd_pkg::RecipW;

  logic [2:0]                       st_q, st_d;
  hlcd_pkg::entry_t                 ent_q, ent_d;
  logic [hlcd_pkg::SqW-1:0]         rad_q, rad_d;
  logic [15:0]                      rem_q, rem_d;
  logic [hlcd_pkg::SpdW-1:0]        root_q, root_d;
  logic [3:0]                       step_q, step_d;
  logic [hlcd_pkg::ProdW-1:0]       prod_q, prod_d;
  logic [hlcd_pkg::PredW-1:0]       pred_q, pred_d;

  logic [hlcd_pkg::LaneW-1:0]       lane_q, lane_d;
  logic [hlcd_pkg::SpeedW-1:0]      speed_q, speed_d;
  logic [hlcd_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic                             close_q, close_d, lfree_q, lfree_d, rfree_q, rfree_d;

  logic                             ovalid_q, ovalid_d;
  logic [hlcd_pkg::LaneW-1:0]       olane_q, olane_d;
  logic [hlcd_pkg::SpeedW-1:0]      ospeed_q, ospeed_d;
  hlcd_pkg::decision_e              odec_q, odec_d;
  logic                             oblk_q, oblk_d;

  logic [17:0]                      rem_sh, trial;
  logic [MqW-1:0]                   mq;
  logic signed [DiffW-1:0]          diff;
  logic signed [hlcd_pkg::DW:0]     dd;
  logic signed [hlcd_pkg::DW+1:0]   d_ext;
  logic [11:0]                      lo_bound;
  logic [12:0]                      hi_bound;
  logic                             gap, left_side, right_side, own_lane, too_close;
  logic                             may_change, out_free;

  assign pop_o    = (st_q == StIdle) && !empty_i;
  assign out_free = !ovalid_q || out_o.ready;

  // one root bit per cycle
  assign rem_sh = {rem_q, rad_q[hlcd_pkg::SqW-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};

  assign mq = MqW'(prod_q) * MqW'(hlcd_pkg::Recip);

  // window checks against the frame reference
  assign diff = $signed({1'b0, pred_q}) - $signed({2'b00, ent_q.ref_s});
  assign gap  = (diff > 0 && diff < $signed(DiffW'(cfg_i.ahead_gap))) ||
                (diff < 0 && (-diff) < $signed(DiffW'(cfg_i.behind_gap)));

  assign dd = $signed({ent_q.ego_d[hlcd_pkg::DW-1], ent_q.ego_d}) -
              $signed({ent_q.other_d[hlcd_pkg::DW-1], ent_q.other_d});
  assign left_side  = dd > 0 && dd < $signed({2'b00, cfg_i.side_window});
  assign right_side = dd < 0 && (-dd) < $signed({2'b00, cfg_i.side_window});

  assign lo_bound = 12'(cfg_i.lane_width * lane_q);
  assign hi_bound = 13'(cfg_i.lane_width * ({1'b0, lane_q} + 3'd1));
  assign d_ext    = $signed({{2{ent_q.other_d[hlcd_pkg::DW-1]}}, ent_q.other_d});
  assign own_lane = d_ext > $signed({3'b000, lo_bound}) &&
                    d_ext < $signed({2'b00, hi_bound});
  assign too_close = own_lane && diff > 0 &&
                     diff < $signed(DiffW'(cfg_i.follow_gap));

  assign may_change = cnt_q > cfg_i.min_change;

  always_comb begin
    st_d     = st_q;
    ent_d    = ent_q;
    rad_d    = rad_q;
    rem_d    = rem_q;
    root_d   = root_q;
    step_d   = step_q;
    prod_d   = prod_q;
    pred_d   = pred_q;
    lane_d   = lane_q;
    speed_d  = speed_q;
    cnt_d    = cnt_q;
    close_d  = close_q;
    lfree_d  = lfree_q;
    rfree_d  = rfree_q;
    ovalid_d = ovalid_q;
    olane_d  = olane_q;
    ospeed_d = ospeed_q;
    odec_d   = odec_q;
    oblk_d   = oblk_q;

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (st_q)
      StIdle: begin
        if (!empty_i) begin
          ent_d  = entry_i;
          rad_d  = entry_i.speed_sq;
          rem_d  = '0;
          root_d = '0;
          step_d = '0;
          if (entry_i.first) begin
            if (cnt_q != {hlcd_pkg::CntW{1'b1}}) begin
              cnt_d = cnt_q + 1'b1;
            end
            close_d = 1'b0;
            lfree_d = 1'b1;
            rfree_d = 1'b1;
          end
          if (entry_i.has_vehicle) begin
            st_d = StRoot;
          end else if (entry_i.last) begin
            st_d = StDecide;
          end
        end
      end
      StRoot: begin
        if (rem_sh >= trial) begin
          rem_d  = 16'(rem_sh - trial);
          root_d = {root_q[hlcd_pkg::SpdW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh[15:0];
          root_d = {root_q[hlcd_pkg::SpdW-2:0], 1'b0};
        end
        rad_d  = rad_q << 2;
        step_d = step_q + 1'b1;
        if (step_q == 4'(hlcd_pkg::RootSteps - 1)) begin
          st_d = StMul1;
        end
      end
      StMul1: begin
        prod_d = ent_q.points * root_q;
        st_d   = StMul2;
      end
      StMul2: begin
        pred_d = {1'b0, ent_q.other_s} +
                 hlcd_pkg::PredW'(mq[hlcd_pkg::RecipShift +: hlcd_pkg::QuotW]);
        st_d   = StEval;
      end
      StEval: begin
        if (lane_q == LastLane) rfree_d = 1'b0;
        if (lane_q == '0) lfree_d = 1'b0;
        if (lane_q != '0 && left_side && gap) lfree_d = 1'b0;
        if (lane_q != LastLane && right_side && gap) rfree_d = 1'b0;
        if (too_close) close_d = 1'b1;
        st_d = ent_q.last ? StDecide : StIdle;
      end
      StDecide: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          oblk_d   = close_q;
          if (close_q && lfree_q && may_change) begin
            cnt_d  = '0;
            if (lane_q != '0) lane_d = lane_q - 1'b1;
            odec_d = hlcd_pkg::DecLeft;
          end else if (close_q && rfree_q && may_change) begin
            cnt_d  = '0;
            if (lane_q != LastLane) lane_d = lane_q + 1'b1;
            odec_d = hlcd_pkg::DecRight;
          end else if (close_q) begin
            if (speed_q != '0) speed_d = speed_q - 1'b1;
            odec_d = hlcd_pkg::DecSlow;
          end else if (speed_q < cfg_i.speed_limit) begin
            speed_d = speed_q + 1'b1;
            odec_d  = hlcd_pkg::DecAccel;
          end else begin
            odec_d = hlcd_pkg::DecHold;
          end
          olane_d  = lane_d;
          ospeed_d = speed_d;
          st_d     = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      lane_q   <= hlcd_pkg::LaneW'(1);
      speed_q  <= '0;
      cnt_q    <= '0;
      close_q  <= 1'b0;
      lfree_q  <= 1'b1;
      rfree_q  <= 1'b1;
      ovalid_q <= 1'b0;
      step_q   <= '0;
    end else begin
      st_q     <= st_d;
      lane_q   <= lane_d;
      speed_q  <= speed_d;
      cnt_q    <= cnt_d;
      close_q  <= close_d;
      lfree_q  <= lfree_d;
      rfree_q  <= rfree_d;
      ovalid_q <= ovalid_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q    <= ent_d;
    rad_q    <= rad_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    prod_q   <= prod_d;
    pred_q   <= pred_d;
    olane_q  <= olane_d;
    ospeed_q <= ospeed_d;
    odec_q   <= odec_d;
    oblk_q   <= oblk_d;
  end

  assign out_o.valid                 = ovalid_q;
  assign out_o.lane_now              = olane_q;
  assign out_o.target_speed_half_mph = ospeed_q;
  assign out_o.decision              = odec_q;
  assign out_o.blocked_ahead         = oblk_q;

endmodule

[rtl/core/highway_lane_change_decider.sv]
// Top level of the highway lane change decider: registers, front, queue, back.
//
//   channel   dir   handshake                  carries
//   in_i      in    valid/ready                one sensed vehicle (or empty) item
//   out_o     out   valid/ready                lane, speed target, decision per frame
//   apb       in    psel/penable/pwrite        seven configuration registers
//
// A vehicle item passes the back end in steps: dequeue, the bit-serial speed
// root, two multiply stages, the gap checks, and on the last item of a frame
// the decision.
// An item without a vehicle is only dequeued, then decided on if it closes a frame.
// The front takes an item per cycle while the 4-entry queue has room.
// A decision waiting on out_o stalls only the back end; the queue keeps filling.
// Reset is asynchronous and active low; no clearing pass is needed.
module highway_lane_change_decider #(
  parameter int LANE_COUNT  = hlcd_pkg::DefLaneCount,
  parameter int PATH_POINTS = hlcd_pkg::DefPathPoints
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  hlcd_in_if.sink                    in_i,
  hlcd_out_if.source                 out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hlcd_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  hlcd_pkg::cfg_t   cfg_q;
  hlcd_pkg::entry_t push_entry, head_entry;
  logic             push, pop, full, empty, wr_en;
  logic [2:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ahead_gap   <= 16'd4000;
      cfg_q.behind_gap  <= 16'd1000;
      cfg_q.follow_gap  <= 16'd3000;
      cfg_q.side_window <= 12'd600;
      cfg_q.lane_width  <= 10'd400;
      cfg_q.min_change  <= 7'd100;
      cfg_q.speed_limit <= 7'd98;
    end else if (wr_en) begin
      case (reg_idx)
        hlcd_pkg::RegAheadGap:   cfg_q.ahead_gap   <= pwdata[15:0];
        hlcd_pkg::RegBehindGap:  cfg_q.behind_gap  <= pwdata[15:0];
        hlcd_pkg::RegFollowGap:  cfg_q.follow_gap  <= pwdata[15:0];
        hlcd_pkg::RegSideWindow: cfg_q.side_window <= pwdata[11:0];
        hlcd_pkg::RegLaneWidth:  cfg_q.lane_width  <= pwdata[9:0];
        hlcd_pkg::RegMinChange:  cfg_q.min_change  <= pwdata[6:0];
        hlcd_pkg::RegSpeedLimit: cfg_q.speed_limit <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hlcd_pkg::RegAheadGap:   prdata = 32'(cfg_q.ahead_gap);
      hlcd_pkg::RegBehindGap:  prdata = 32'(cfg_q.behind_gap);
      hlcd_pkg::RegFollowGap:  prdata = 32'(cfg_q.follow_gap);
      hlcd_pkg::RegSideWindow: prdata = 32'(cfg_q.side_window);
      hlcd_pkg::RegLaneWidth:  prdata = 32'(cfg_q.lane_width);
      hlcd_pkg::RegMinChange:  prdata = 32'(cfg_q.min_change);
      hlcd_pkg::RegSpeedLimit: prdata = 32'(cfg_q.speed_limit);
      default:                 prdata = '0;
    endcase
  end

  hlcd_front #(
    .PATH_POINTS (PATH_POINTS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  hlcd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  hlcd_back #(
    .LANE_COUNT (LANE_COUNT)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .entry_i (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  // the queue cannot be full and empty at once
  a_queue_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full && empty))
    else $error("queue reports full and empty together");

  // the selected lane never leaves the road
  a_lane_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.lane_now <= 2'(LANE_COUNT - 1)))
    else $error("lane out of range");

  // a lane change or a slow down happens exactly when a close vehicle blocks the way ahead
  a_dec_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.decision == hlcd_pkg::DecLeft ||
                      out_o.decision == hlcd_pkg::DecRight ||
                      out_o.decision == hlcd_pkg::DecSlow) == out_o.blocked_ahead))
    else $error("decision disagrees with blocked flag");

  // an item is popped from the queue only when something is there
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule
